### design/area_average_image_downscaler_defines.svh
// Assertion macros used by the downscaler top level.
`ifndef AREA_AVERAGE_IMAGE_DOWNSCALER_DEFINES_SVH
`define AREA_AVERAGE_IMAGE_DOWNSCALER_DEFINES_SVH
// consequent must hold in the same cycle as the antecedent
`define AAID_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aaid same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define AAID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aaid next-cycle check failed");
`endif

### design/aaid_pkg.sv
// Shared constants, codes and controller/datapath types of the downscaler.
`default_nettype none
package aaid_pkg;
	localparam int MAX_SOURCE_SIZE_D  = 4096;
	localparam int MAX_TARGET_WIDTH_D = 1024;
	localparam int PIX_W       = 8;
	localparam int COL_W       = 10;
	localparam int ROW_W       = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int SRC_REG_W   = 13;
	localparam int TGT_W_REG_W = 11;
	localparam int DIV_STEPS   = 8;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_TARGET_WIDTH  = 3'd2,
		REG_TARGET_HEIGHT = 3'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_CALC,
		ST_RD1,
		ST_MUL1,
		ST_MUL2,
		ST_WR0,
		ST_WR1,
		ST_DIV,
		ST_OUTW,
		ST_ADV
	} state_t;

	typedef struct packed {
		logic restart;
		logic latch_pix;
		logic clr_we;
		logic calc;
		logic rd_next;
		logic cap0;
		logic cap1;
		logic mul1;
		logic mul2;
		logic wr0;
		logic wr1;
		logic div_step;
		logic out_load;
		logic adv;
	} ctrl_cmd_t;

	typedef struct packed {
		logic emit;
		logic frame_wrap;
		logic clr_done;
		logic div_done;
		logic out_full;
		logic cfg_restart;
	} ctrl_sts_t;
endpackage
`default_nettype wire

### design/aaid_pix_if.sv
// Source pixel channel.
`default_nettype none
interface aaid_pix_if import aaid_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] in_red;
	logic [PIX_W-1:0] in_green;
	logic [PIX_W-1:0] in_blue;
	logic             frame_start;
	modport source (output valid, in_red, in_green, in_blue, frame_start, input ready);
	modport sink (input valid, in_red, in_green, in_blue, frame_start, output ready);
endinterface
`default_nettype wire

### design/aaid_res_if.sv
// Output pixel channel.
`default_nettype none
interface aaid_res_if import aaid_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;
	logic [COL_W-1:0] out_col;
	logic [ROW_W-1:0] out_row;
	logic             frame_last;
	modport source (output valid, out_red, out_green, out_blue, out_col, out_row, frame_last,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_col, out_row, frame_last,
		output ready);
endinterface
`default_nettype wire

### design/aaid_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface aaid_cfg_if import aaid_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/aaid_ctrl.sv
// Controller state machine: sequences clear sweep, accumulate, divide and emit.
`default_nettype none
module aaid_ctrl import aaid_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic frame_start,
	output logic      in_ready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);
	state_t state_q, state_d;
	logic   need_clr_q;
	logic   dirty_q;
	logic   pend_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (need_clr_q) begin
					state_d = ST_CLEAR;
				end else if (in_valid) begin
					state_d = (frame_start && dirty_q) ? ST_CLEAR : ST_CALC;
				end
			end
			ST_CLEAR: begin
				if (sts.clr_done) begin
					state_d = pend_q ? ST_CALC : ST_IDLE;
				end
			end
			ST_CALC: state_d = ST_RD1;
			ST_RD1:  state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_WR0;
			ST_WR0:  state_d = ST_WR1;
			ST_WR1:  state_d = sts.emit ? ST_DIV : ST_ADV;
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_OUTW;
				end
			end
			ST_OUTW: begin
				if (!sts.out_full) begin
					state_d = ST_ADV;
				end
			end
			ST_ADV:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !need_clr_q;
				if (in_valid && !need_clr_q) begin
					cmd.latch_pix = 1'b1;
					cmd.restart   = frame_start;
				end
			end
			ST_CLEAR: cmd.clr_we = 1'b1;
			ST_CALC:  cmd.calc = 1'b1;
			ST_RD1: begin
				cmd.rd_next = 1'b1;
				cmd.cap0    = 1'b1;
			end
			ST_MUL1: begin
				cmd.cap1 = 1'b1;
				cmd.mul1 = 1'b1;
			end
			ST_MUL2:  cmd.mul2 = 1'b1;
			ST_WR0:   cmd.wr0 = 1'b1;
			ST_WR1:   cmd.wr1 = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_OUTW:  cmd.out_load = !sts.out_full;
			ST_ADV:   cmd.adv = 1'b1;
			default:  cmd = '0;
		endcase
	end

	// state and bookkeeping flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			need_clr_q <= 1'b1;
			dirty_q    <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sts.cfg_restart && dirty_q) begin
				need_clr_q <= 1'b1;
			end else if (sts.clr_done) begin
				need_clr_q <= 1'b0;
			end
			if (sts.clr_done) begin
				dirty_q <= 1'b0;
			end else if (cmd.adv) begin
				dirty_q <= !sts.frame_wrap;
			end
			if (cmd.latch_pix) begin
				pend_q <= 1'b1;
			end else if (cmd.adv) begin
				pend_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### design/aaid_dp.sv
// Datapath: config registers, position counters, sum memory, multipliers, divider.
`default_nettype none
module aaid_dp import aaid_pkg::*; #(
	parameter int MAX_SOURCE_SIZE  = MAX_SOURCE_SIZE_D,
	parameter int MAX_TARGET_WIDTH = MAX_TARGET_WIDTH_D
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctrl_cmd_t        cmd,
	output ctrl_sts_t             sts,
	input  wire logic             cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [PIX_W-1:0] in_red,
	input  wire logic [PIX_W-1:0] in_green,
	input  wire logic [PIX_W-1:0] in_blue,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic [PIX_W-1:0]      out_red,
	output logic [PIX_W-1:0]      out_green,
	output logic [PIX_W-1:0]      out_blue,
	output logic [COL_W-1:0]      out_col,
	output logic [ROW_W-1:0]      out_row,
	output logic                  frame_last
);
	localparam int NCH    = 3;
	localparam int SZ_W   = $clog2(MAX_SOURCE_SIZE + 1);
	localparam int SA_W   = $clog2(MAX_SOURCE_SIZE);
	localparam int TWS_W  = $clog2(MAX_TARGET_WIDTH + 1);
	localparam int TA_W   = $clog2(MAX_TARGET_WIDTH);
	localparam int XB_W   = SZ_W + TWS_W + 1;
	localparam int YB_W   = 2 * SZ_W + 1;
	localparam int AREA_W = 2 * SZ_W;
	localparam int SUM_W  = PIX_W + 2 * SZ_W;
	localparam int P1_W   = PIX_W + TWS_W;
	localparam int P2_W   = P1_W + SZ_W;
	localparam int DIV_W  = SUM_W + 2;
	localparam int MEM_W  = 2 * NCH * SUM_W;

	// size clamping
	function automatic logic [SZ_W-1:0] clamp_src(input logic [SRC_REG_W-1:0] v);
		if (v == '0) begin
			return SZ_W'(1);
		end else if (32'(v) > 32'(MAX_SOURCE_SIZE)) begin
			return SZ_W'(MAX_SOURCE_SIZE);
		end
		return SZ_W'(v);
	endfunction

	logic [SRC_REG_W-1:0]   sw_reg_q, sh_reg_q, th_reg_q;
	logic [TGT_W_REG_W-1:0] tw_reg_q;
	logic [SZ_W-1:0]        sw, sh, th, th_raw;
	logic [TWS_W-1:0]       tw, tw_raw;
	logic [AREA_W-1:0]      area_q;
	logic                   cfg_hit;

	logic [SA_W-1:0] x_q, y_q, cy_q;
	logic [TA_W-1:0] cx_q;
	logic [XB_W-1:0] px0_q, bx0_q, a1x, b1x;
	logic [YB_W-1:0] py0_q, by0_q, a1y, b1y;
	logic            x_last, y_last, has_next_c, last_pix_c;

	logic [PIX_W-1:0] pix_q [NCH];
	logic [TWS_W-1:0] wx0_q, wx1_q;
	logic [SZ_W-1:0]  wy0_q, wy1_q;
	logic             col_last_q, row_last_q, has_next_q;
	logic [P1_W-1:0]  p1_q [NCH][2];
	logic [SUM_W-1:0] p2_q [NCH][2][2];

	logic [MEM_W-1:0] mem [MAX_TARGET_WIDTH];
	logic [MEM_W-1:0] rdata_q, ent0_q, ent1_q, new0, new1, wdata;
	logic [TA_W-1:0]  raddr, waddr, clr_addr_q;
	logic             we;

	logic [DIV_W-1:0]     rem_q [NCH];
	logic [PIX_W-1:0]     quo_q [NCH];
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [DIV_W-1:0]     dsh;

	// effective sizes
	always_comb begin
		sw     = clamp_src(sw_reg_q);
		sh     = clamp_src(sh_reg_q);
		th_raw = clamp_src(th_reg_q);
		th     = (th_raw > sh) ? sh : th_raw;
		if (tw_reg_q == '0) begin
			tw_raw = TWS_W'(1);
		end else if (32'(tw_reg_q) > 32'(MAX_TARGET_WIDTH)) begin
			tw_raw = TWS_W'(MAX_TARGET_WIDTH);
		end else begin
			tw_raw = TWS_W'(tw_reg_q);
		end
		tw = (32'(tw_raw) > 32'(sw)) ? TWS_W'(sw) : tw_raw;
	end

	assign cfg_hit = cfg_we && (cfg_idx <= REG_TARGET_HEIGHT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_reg_q <= SRC_REG_W'(1);
			sh_reg_q <= SRC_REG_W'(1);
			tw_reg_q <= TGT_W_REG_W'(1);
			th_reg_q <= SRC_REG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_SOURCE_WIDTH:  sw_reg_q <= SRC_REG_W'(cfg_data);
				REG_SOURCE_HEIGHT: sh_reg_q <= SRC_REG_W'(cfg_data);
				REG_TARGET_WIDTH:  tw_reg_q <= TGT_W_REG_W'(cfg_data);
				REG_TARGET_HEIGHT: th_reg_q <= SRC_REG_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// output pixel area, stable while configuration holds
	always_ff @(posedge clk) begin
		area_q <= AREA_W'(sw) * AREA_W'(sh);
	end

	// overlap of the current source pixel with output columns cx and cx+1
	always_comb begin
		a1x        = px0_q + XB_W'(tw);
		b1x        = bx0_q + XB_W'(sw);
		a1y        = py0_q + YB_W'(th);
		b1y        = by0_q + YB_W'(sh);
		x_last     = (SZ_W'(x_q) + SZ_W'(1)) >= sw;
		y_last     = (SZ_W'(y_q) + SZ_W'(1)) >= sh;
		has_next_c = (TWS_W'(cx_q) + TWS_W'(1)) < tw;
		last_pix_c = ((TWS_W'(cx_q) + TWS_W'(1)) == tw) && ((SZ_W'(cy_q) + SZ_W'(1)) == th);
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			cx_q  <= '0;
			cy_q  <= '0;
			px0_q <= '0;
			bx0_q <= '0;
			py0_q <= '0;
			by0_q <= '0;
		end else if (cmd.restart || cfg_hit) begin
			x_q   <= '0;
			y_q   <= '0;
			cx_q  <= '0;
			cy_q  <= '0;
			px0_q <= '0;
			bx0_q <= '0;
			py0_q <= '0;
			by0_q <= '0;
		end else if (cmd.adv) begin
			if (x_last) begin
				x_q   <= '0;
				px0_q <= '0;
				cx_q  <= '0;
				bx0_q <= '0;
				if (y_last) begin
					y_q   <= '0;
					py0_q <= '0;
					cy_q  <= '0;
					by0_q <= '0;
				end else begin
					y_q   <= y_q + SA_W'(1);
					py0_q <= a1y;
					if (row_last_q) begin
						cy_q  <= cy_q + SA_W'(1);
						by0_q <= b1y;
					end
				end
			end else begin
				x_q   <= x_q + SA_W'(1);
				px0_q <= a1x;
				if (col_last_q) begin
					cx_q  <= cx_q + TA_W'(1);
					bx0_q <= b1x;
				end
			end
		end
	end

	// pixel, weights and products
	always_ff @(posedge clk) begin
		if (cmd.latch_pix) begin
			pix_q[0] <= in_red;
			pix_q[1] <= in_green;
			pix_q[2] <= in_blue;
		end
		if (cmd.calc) begin
			wx0_q      <= TWS_W'(((a1x < b1x) ? a1x : b1x) - px0_q);
			wx1_q      <= (a1x > b1x) ? TWS_W'(a1x - b1x) : '0;
			wy0_q      <= SZ_W'(((a1y < b1y) ? a1y : b1y) - py0_q);
			wy1_q      <= (a1y > b1y) ? SZ_W'(a1y - b1y) : '0;
			col_last_q <= b1x <= a1x;
			row_last_q <= b1y <= a1y;
			has_next_q <= has_next_c;
		end
		for (int c = 0; c < NCH; c++) begin
			if (cmd.mul1) begin
				p1_q[c][0] <= P1_W'(pix_q[c]) * P1_W'(wx0_q);
				p1_q[c][1] <= P1_W'(pix_q[c]) * P1_W'(wx1_q);
			end
			if (cmd.mul2) begin
				for (int k = 0; k < 2; k++) begin
					p2_q[c][k][0] <= SUM_W'(P2_W'(p1_q[c][k]) * P2_W'(wy0_q));
					p2_q[c][k][1] <= SUM_W'(P2_W'(p1_q[c][k]) * P2_W'(wy1_q));
				end
			end
		end
	end

	// updated sums of columns cx and cx+1
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			new0[c*SUM_W +: SUM_W] = ent0_q[c*SUM_W +: SUM_W] + p2_q[c][0][0];
			new0[(NCH+c)*SUM_W +: SUM_W] = ent0_q[(NCH+c)*SUM_W +: SUM_W] + p2_q[c][0][1];
			new1[c*SUM_W +: SUM_W] = ent1_q[c*SUM_W +: SUM_W] + p2_q[c][1][0];
			new1[(NCH+c)*SUM_W +: SUM_W] = ent1_q[(NCH+c)*SUM_W +: SUM_W] + p2_q[c][1][1];
		end
	end

	// memory port selection; an emitted column moves its next-row sums up
	always_comb begin
		raddr = cmd.rd_next ? (cx_q + TA_W'(1)) : cx_q;
		we    = cmd.clr_we || cmd.wr0 || (cmd.wr1 && has_next_q);
		if (cmd.clr_we) begin
			waddr = clr_addr_q;
			wdata = '0;
		end else if (cmd.wr0) begin
			waddr = cx_q;
			if (col_last_q && row_last_q) begin
				wdata = {{(NCH*SUM_W){1'b0}}, new0[NCH*SUM_W +: NCH*SUM_W]};
			end else begin
				wdata = new0;
			end
		end else begin
			waddr = cx_q + TA_W'(1);
			wdata = new1;
		end
	end

	// column sum memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
		if (cmd.cap0) begin
			ent0_q <= rdata_q;
		end
		if (cmd.cap1) begin
			ent1_q <= rdata_q;
		end
	end

	// clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_addr_q <= (clr_addr_q == TA_W'(MAX_TARGET_WIDTH - 1)) ? '0 :
				clr_addr_q + TA_W'(1);
		end
	end

	// restoring divider, one quotient bit per cycle for all channels
	assign dsh = DIV_W'(area_q) << ({1'b0, div_cnt_q} + (DIV_CNT_W + 1)'(1));

	always_ff @(posedge clk) begin
		if (cmd.wr0 && col_last_q && row_last_q) begin
			div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
			for (int c = 0; c < NCH; c++) begin
				rem_q[c] <= (DIV_W'(new0[c*SUM_W +: SUM_W]) << 1) + DIV_W'(area_q);
				quo_q[c] <= '0;
			end
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			for (int c = 0; c < NCH; c++) begin
				if (rem_q[c] >= dsh) begin
					rem_q[c]            <= rem_q[c] - dsh;
					quo_q[c][div_cnt_q] <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_red    <= quo_q[0];
			out_green  <= quo_q[1];
			out_blue   <= quo_q[2];
			out_col    <= COL_W'(cx_q);
			out_row    <= ROW_W'(cy_q);
			frame_last <= last_pix_c;
		end
	end

	// status toward the controller
	always_comb begin
		sts.emit        = col_last_q && row_last_q;
		sts.frame_wrap  = x_last && y_last;
		sts.clr_done    = cmd.clr_we && (clr_addr_q == TA_W'(MAX_TARGET_WIDTH - 1));
		sts.div_done    = div_cnt_q == '0;
		sts.out_full    = out_valid;
		sts.cfg_restart = cfg_hit;
	end
endmodule
`default_nettype wire

### design/area_average_image_downscaler.sv
// Top level of the area-averaging RGB image downscaler.
// Usage:
//   pix: source pixels in raster order; frame_start on a pixel restarts the frame.
//   res: averaged output pixels with column, row and a last-of-frame flag.
//   cfg: register writes (0 source width, 1 source height, 2 target width,
//        3 target height); a write to a listed register restarts the frame.
// One pixel is worked on at a time: pix.ready stays low from acceptance until
// the pixel is done (calculate weights, read the two column entries, multiply
// twice, write two entries and, for a pixel that completes an output pixel, run
// the bit-serial divider, one quotient bit per cycle, and load the output
// register once the previous result has been taken).
// The result sits in res in an output register, so a stalled receiver only
// blocks the block at the next result. The per-pixel work is a read-modify-write
// sequence on the column sum memory (two entries per pixel), followed by the
// divider for a pixel that completes an output pixel.
// After reset, and after a restart that leaves a frame unfinished, the block
// clears all MAX_TARGET_WIDTH entries of the sum memory with pix.ready low;
// configuration writes are taken at any time.
`default_nettype none
`include "area_average_image_downscaler_defines.svh"
module area_average_image_downscaler import aaid_pkg::*; #(
	parameter int MAX_SOURCE_SIZE  = MAX_SOURCE_SIZE_D,
	parameter int MAX_TARGET_WIDTH = MAX_TARGET_WIDTH_D
) (
	input wire logic  clk,
	input wire logic  arst_n,
	aaid_pix_if.sink   pix,
	aaid_res_if.source res,
	aaid_cfg_if.sink   cfg
);
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg.ready = 1'b1;

	aaid_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pix.valid),
		.frame_start (pix.frame_start),
		.in_ready    (pix.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	aaid_dp #(
		.MAX_SOURCE_SIZE  (MAX_SOURCE_SIZE),
		.MAX_TARGET_WIDTH (MAX_TARGET_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg.valid),
		.cfg_idx    (cfg.index),
		.cfg_data   (cfg.data),
		.in_red     (pix.in_red),
		.in_green   (pix.in_green),
		.in_blue    (pix.in_blue),
		.out_ready  (res.ready),
		.out_valid  (res.valid),
		.out_red    (res.out_red),
		.out_green  (res.out_green),
		.out_blue   (res.out_blue),
		.out_col    (res.out_col),
		.out_row    (res.out_row),
		.frame_last (res.frame_last)
	);

	// no pixel taken while the sum memory is swept
	`AAID_ASSERT_SAME(a_clear_blocks_input, clk, arst_n, cmd.clr_we, !pix.ready)
	// one pixel in flight at a time
	`AAID_ASSERT_NEXT(a_one_in_flight, clk, arst_n, pix.valid && pix.ready, !pix.ready)
	// a pending result is never overwritten
	`AAID_ASSERT_SAME(a_no_result_overwrite, clk, arst_n, cmd.out_load, !res.valid)
endmodule
`default_nettype wire

### sim/area_average_image_downscaler_tb.sv
// Self-checking testbench for the area-averaging image downscaler.
`default_nettype none
module area_average_image_downscaler_tb;
	import aaid_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 60000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic [7:0] r, g, b;
		logic       fs;
		bit         hold;    // wait for all outputs before sending
	} src_pixel_t;

	typedef struct {
		logic [7:0]       r, g, b;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} avg_pixel_t;

	logic clk;
	logic arst_n;

	aaid_pix_if pix ();
	aaid_res_if res ();
	aaid_cfg_if cfg ();

	area_average_image_downscaler u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	src_pixel_t pixel_q[$];
	avg_pixel_t avg_q[$];
	int         send_idle_pct;
	int         recv_stall_pct;
	bit         pix_took;
	int         errors;
	int         n_pixels, n_outputs, n_writes;
	int         quiet_cycles;

	// shadow of the registers and of the accumulation state
	logic [12:0]     sh_sw, sh_sh, sh_th;
	logic [10:0]     sh_tw;
	int unsigned     src_x, src_y, tgt_x, tgt_y;
	longint unsigned sum_cur[MAX_TARGET_WIDTH_D][3];
	longint unsigned sum_nxt[MAX_TARGET_WIDTH_D][3];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned eff_size(int unsigned v, int unsigned maxv);
		if (v == 0)
			return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic longint unsigned span(longint unsigned a0, longint unsigned a1,
		longint unsigned b0, longint unsigned b1);
		longint unsigned lo, hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a1 < b1) ? a1 : b1;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	function automatic void clear_frame();
		src_x = 0;
		src_y = 0;
		tgt_x = 0;
		tgt_y = 0;
		for (int i = 0; i < MAX_TARGET_WIDTH_D; i++)
			for (int c = 0; c < 3; c++) begin
				sum_cur[i][c] = 0;
				sum_nxt[i][c] = 0;
			end
	endfunction

	// accumulate one source pixel; queue an output pixel when one completes
	function automatic void accumulate_pixel(src_pixel_t p);
		longint unsigned sw, sh, tw, th, px0, px1, py0, py1, wx0, wx1, wy0, wy1, a, s;
		longint unsigned v[3];
		bit col_done, row_done;
		avg_pixel_t o;
		sw = eff_size(sh_sw, MAX_SOURCE_SIZE_D);
		sh = eff_size(sh_sh, MAX_SOURCE_SIZE_D);
		tw = eff_size(sh_tw, MAX_TARGET_WIDTH_D);
		th = eff_size(sh_th, MAX_SOURCE_SIZE_D);
		if (tw > sw) tw = sw;
		if (th > sh) th = sh;
		v[0] = p.r;
		v[1] = p.g;
		v[2] = p.b;
		if (p.fs || src_x >= sw || src_y >= sh || tgt_x >= tw || tgt_y >= th)
			clear_frame();
		px0 = src_x * tw;
		px1 = px0 + tw;
		py0 = src_y * th;
		py1 = py0 + th;
		wx0 = span(px0, px1, tgt_x * sw, (tgt_x + 1) * sw);
		wx1 = (tgt_x + 1 < tw) ? span(px0, px1, (tgt_x + 1) * sw, (tgt_x + 2) * sw) : 0;
		wy0 = span(py0, py1, tgt_y * sh, (tgt_y + 1) * sh);
		wy1 = (tgt_y + 1 < th) ? span(py0, py1, (tgt_y + 1) * sh, (tgt_y + 2) * sh) : 0;
		for (int c = 0; c < 3; c++) begin
			sum_cur[tgt_x][c] += v[c] * wx0 * wy0;
			sum_nxt[tgt_x][c] += v[c] * wx0 * wy1;
			if (tgt_x + 1 < tw) begin
				sum_cur[tgt_x + 1][c] += v[c] * wx1 * wy0;
				sum_nxt[tgt_x + 1][c] += v[c] * wx1 * wy1;
			end
		end
		col_done = ((tgt_x + 1) * sw <= px1);
		row_done = ((tgt_y + 1) * sh <= py1);
		if (col_done && row_done) begin
			a = sw * sh;
			for (int c = 0; c < 3; c++) begin
				s = sum_cur[tgt_x][c];
				v[c] = (2 * s + a) / (2 * a);
				sum_cur[tgt_x][c] = sum_nxt[tgt_x][c];
				sum_nxt[tgt_x][c] = 0;
			end
			o.r = v[0][7:0];
			o.g = v[1][7:0];
			o.b = v[2][7:0];
			o.col = tgt_x[COL_W-1:0];
			o.row = tgt_y[ROW_W-1:0];
			o.last = (tgt_x + 1 == tw && tgt_y + 1 == th);
			avg_q.push_back(o);
		end
		if (col_done) tgt_x++;
		src_x++;
		if (src_x >= sw) begin
			src_x = 0;
			tgt_x = 0;
			src_y++;
			if (row_done) tgt_y++;
			if (src_y >= sh) begin
				src_y = 0;
				tgt_y = 0;
			end
		end
	endfunction

	// source pixel driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!pix.valid || pix_took) begin
				if (pixel_q.size() > 0 && !(pixel_q[0].hold && avg_q.size() > 0) &&
					$urandom_range(99) >= send_idle_pct) begin
					pix.in_red      <= pixel_q[0].r;
					pix.in_green    <= pixel_q[0].g;
					pix.in_blue     <= pixel_q[0].b;
					pix.frame_start <= pixel_q[0].fs;
					pix.valid       <= 1'b1;
					void'(pixel_q.pop_front());
				end else begin
					pix.valid <= 1'b0;
				end
			end
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on accepted pixels, check accepted outputs
	always @(posedge clk) begin
		avg_pixel_t e;
		pix_took <= pix.valid && pix.ready;
		if (arst_n) begin
			if (pix.valid && pix.ready) begin
				src_pixel_t p;
				p.r = pix.in_red;
				p.g = pix.in_green;
				p.b = pix.in_blue;
				p.fs = pix.frame_start;
				p.hold = 1'b0;
				accumulate_pixel(p);
				n_pixels++;
			end
			if (res.valid && res.ready) begin
				n_outputs++;
				if (avg_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected output pixel col %0d row %0d", $time,
						res.out_col, res.out_row);
				end else begin
					e = avg_q.pop_front();
					if (res.out_red !== e.r || res.out_green !== e.g ||
						res.out_blue !== e.b || res.out_col !== e.col ||
						res.out_row !== e.row || res.frame_last !== e.last) begin
						errors++;
						$display("%0t: mismatch exp rgb %0d/%0d/%0d col %0d row %0d last %0b",
							$time, e.r, e.g, e.b, e.col, e.row, e.last);
						$display("%0t:          got rgb %0d/%0d/%0d col %0d row %0d last %0b",
							$time, res.out_red, res.out_green, res.out_blue, res.out_col,
							res.out_row, res.frame_last);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL area_average_image_downscaler");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pixel_q.size() > 0 || pix.valid || avg_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [12:0] val);
		@(negedge clk);
		cfg.index <= idx;
		cfg.data  <= val;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_SOURCE_WIDTH:  sh_sw = val;
			REG_SOURCE_HEIGHT: sh_sh = val;
			REG_TARGET_WIDTH:  sh_tw = val[10:0];
			default:           sh_th = val;
		endcase
		clear_frame();
		n_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_sizes(int sw, int sh, int tw, int th);
		wait_idle();
		write_reg(REG_SOURCE_WIDTH, sw[12:0]);
		write_reg(REG_SOURCE_HEIGHT, sh[12:0]);
		write_reg(REG_TARGET_WIDTH, tw[12:0]);
		write_reg(REG_TARGET_HEIGHT, th[12:0]);
	endtask

	task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit fs, bit hold);
		src_pixel_t p;
		p.r = r;
		p.g = g;
		p.b = b;
		p.fs = fs;
		p.hold = hold;
		pixel_q.push_back(p);
	endtask

	task automatic push_frame(int count, bit fs, bit hold);
		for (int i = 0; i < count; i++)
			push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
				fs && i == 0, hold && i == 0);
	endtask

	initial begin
		int sw, sh, tw, th, sent;
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.in_red = '0;
		pix.in_green = '0;
		pix.in_blue = '0;
		pix.frame_start = 1'b0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		pix_took = 1'b0;
		errors = 0;
		n_pixels = 0;
		n_outputs = 0;
		n_writes = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sh_sw = 1;
		sh_sh = 1;
		sh_tw = 1;
		sh_th = 1;
		clear_frame();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset sizes: every pixel is its own output; channel extremes
		push_pixel(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
		push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
		push_pixel(8'hAA, 8'h55, 8'hFF, 1'b0, 1'b0);
		// even 2:1 reduction, all white then all black
		set_sizes(4, 4, 2, 2);
		for (int i = 0; i < 16; i++) push_pixel(8'hFF, 8'hFF, 8'hFF, i == 0, 1'b0);
		for (int i = 0; i < 16; i++) push_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
		// uneven ratio with fractional edge weights
		set_sizes(5, 3, 2, 2);
		push_frame(15, 1'b1, 1'b0);
		// zero-valued registers act as one
		set_sizes(0, 0, 0, 0);
		push_frame(3, 1'b0, 1'b0);
		// target larger than source saturates to the source size
		set_sizes(3, 2, 7, 9);
		push_frame(6, 1'b0, 1'b0);
		// frame start in the middle of a frame restarts it
		set_sizes(4, 2, 3, 2);
		push_frame(5, 1'b1, 1'b0);
		push_frame(8, 1'b1, 1'b0);
		// oversized registers saturate; a few pixels then abort by a write
		set_sizes(8191, 8191, 2047, 8191);
		push_frame(6, 1'b1, 1'b0);

		// random frames under rotating idle modes
		sent = 0;
		for (int ph = 0; sent < 720 || ph < 5; ph++) begin
			case (ph % 5)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				3: begin send_idle_pct = 38; recv_stall_pct = 38; end
				default: begin send_idle_pct = $urandom_range(20); recv_stall_pct = 0; end
			endcase
			sw = $urandom_range(1, 12);
			sh = $urandom_range(1, 10);
			tw = ($urandom_range(9) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, sw);
			th = ($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, sh);
			set_sizes(sw, sh, tw, th);
			for (int f = 0; f < 3; f++) begin
				if ($urandom_range(9) == 0) begin
					// broken frame: a frame start and at most a full frame of pixels
					push_frame($urandom_range(1, sw * sh), 1'b1, 1'b0);
					sent += sw * sh;
				end
				push_frame(sw * sh, $urandom_range(1), ph % 7 == 6);
				sent += sw * sh;
			end
		end

		wait_idle();
		$display("Covered %0d source pixels, %0d output pixels, %0d register writes,",
			n_pixels, n_outputs, n_writes);
		$display("with random sizes, saturation, zero sizes and mid-frame restarts.");
		if (errors == 0 && avg_q.size() == 0)
			$display("PASS area_average_image_downscaler");
		else
			$display("FAIL area_average_image_downscaler");
		$finish;
	end
endmodule
`default_nettype wire
